FILE: rtl/core/pfa_pkg.sv
// Shared constants, request and status codes, and the controller/datapath
// interface structs of the paged frame allocator.
// No dependencies.
package pfa_pkg;

  localparam int NUM_FRAMES = 256;
  localparam int NUM_PROCS  = 16;
  localparam int MAX_PAGES  = 256;

  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int SLOT_W  = $clog2(NUM_PROCS);
  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int FC_W    = 9;
  localparam int ADDR_W  = SLOT_W + PAGE_W;
  localparam int DEPTH   = NUM_PROCS * MAX_PAGES;

  // Field and register widths.
  localparam int REQ_W   = 2;
  localparam int PNUM_W  = 16;
  localparam int BYTES_W = 16;
  localparam int PSZ_W   = 13;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 1;
  localparam int CDAT_W  = 13;

  // Divider widths: dividend is bytes plus page size minus one.
  localparam int DVD_W  = 17;
  localparam int REM_W  = PSZ_W + 1;
  localparam int DIVC_W = $clog2(DVD_W + 1);

  // Request types.
  localparam logic [REQ_W-1:0] REQ_XLAT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RESIZE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM       = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_PAGE_SIZE   = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_COUNT = 1'd1;

  localparam logic [PSZ_W-1:0] PAGE_SIZE_RST   = 13'd32;
  localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 9'd256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              div_step;
    logic              scan_clr;
    logic              count_step;
    logic              alloc_step;
    logic              shr_rd;
    logic              shr_free;
    logic              xlat_rd;
    logic              commit;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic              out_frame_sel;
  } pfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             div_done;
    logic             want_big;
    logic             grow;
    logic             shrink;
    logic             scan_end;
    logic             count_short;
    logic             alloc_done;
    logic             xlat_hit;
    logic             out_free;
  } pfa_stat_t;

endpackage

FILE: rtl/core/pfa_ctrl.sv
// Controller state machine of the paged frame allocator.
// Depends on pfa_pkg; drives the datapath in pfa_dp through pfa_cmd_t.
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfa_pkg::pfa_stat_t stat,
  output pfa_pkg::pfa_cmd_t  cmd
);
  import pfa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_COUNT  = 4'd4;
  localparam logic [3:0] S_ALLOC  = 4'd5;
  localparam logic [3:0] S_SHR_RD = 4'd6;
  localparam logic [3:0] S_SHR_FR = 4'd7;
  localparam logic [3:0] S_XLAT   = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  logic [3:0]        state, state_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              res_sel, res_sel_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_sel_next    = res_sel;
    cmd             = '0;
    cmd.out_status  = res_status;
    cmd.out_frame_sel = res_sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        res_sel_next = 1'b0;
        case (stat.req)
          REQ_XLAT:    state_next = S_XLAT;
          REQ_RESIZE:  state_next = S_DIV;
          REQ_RELEASE: state_next = S_SHR_RD;
          default: begin
            res_status_next = ST_OK;
            state_next      = S_RESULT;
          end
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_CHECK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.want_big) begin
          res_status_next = ST_OOM;
          state_next      = S_RESULT;
        end else if (stat.grow) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_COUNT;
        end else if (stat.shrink) begin
          state_next = S_SHR_RD;
        end else begin
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end
      S_COUNT: begin
        if (stat.scan_end) begin
          if (stat.count_short) begin
            res_status_next = ST_OOM;
            state_next      = S_RESULT;
          end else begin
            cmd.scan_clr = 1'b1;
            state_next   = S_ALLOC;
          end
        end else begin
          cmd.count_step = 1'b1;
        end
      end
      S_ALLOC: begin
        if (stat.alloc_done) begin
          cmd.commit      = 1'b1;
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end else begin
          cmd.alloc_step = 1'b1;
        end
      end
      S_SHR_RD: begin
        if (stat.shrink) begin
          cmd.shr_rd = 1'b1;
          state_next = S_SHR_FR;
        end else begin
          cmd.commit      = 1'b1;
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end
      S_SHR_FR: begin
        cmd.shr_free = 1'b1;
        state_next   = S_SHR_RD;
      end
      S_XLAT: begin
        if (stat.xlat_hit) begin
          cmd.xlat_rd     = 1'b1;
          res_status_next = ST_OK;
          res_sel_next    = 1'b1;
        end else begin
          res_status_next = ST_NOT_FOUND;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and pending result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    res_status <= res_status_next;
    res_sel    <= res_sel_next;
  end

endmodule

FILE: rtl/core/pfa_dp.sv
// Datapath of the paged frame allocator: configuration, divider, free bitmap,
// page counts, page table memory and result register. Depends on pfa_pkg.
module pfa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [pfa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CDAT_W-1:0]   cfg_data,
  input  logic [pfa_pkg::REQ_W-1:0]    req_type,
  input  logic [3:0]                   proc_slot,
  input  logic [pfa_pkg::PNUM_W-1:0]   page_number,
  input  logic [pfa_pkg::BYTES_W-1:0]  new_size_bytes,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [pfa_pkg::STAT_W-1:0]   status,
  output logic [7:0]                   frame_number,
  input  pfa_pkg::pfa_cmd_t            cmd,
  output pfa_pkg::pfa_stat_t           stat
);
  import pfa_pkg::*;

  logic [PSZ_W-1:0]   page_size;
  logic [FC_W-1:0]    frame_count;
  logic [REQ_W-1:0]   req;
  logic [SLOT_W-1:0]  slot;
  logic [PNUM_W-1:0]  page;
  logic [DVD_W-1:0]   dvd;
  logic [REM_W-1:0]   rem;
  logic [DVD_W-1:0]   want;
  logic [DIVC_W-1:0]  div_cnt;
  logic [CNT_W-1:0]   have;
  logic [FC_W-1:0]    scan;
  logic [CNT_W-1:0]   nfree;
  logic [NUM_FRAMES-1:0] frame_free;
  logic [CNT_W-1:0]   page_count [NUM_PROCS];
  logic [FRAME_W-1:0] table_mem [DEPTH];
  logic [FRAME_W-1:0] rd_data;

  logic [PSZ_W-1:0]   ps_eff;
  logic [FC_W-1:0]    fc_eff;
  logic [REM_W-1:0]   rem_sh;
  logic               rem_ge;
  logic [CNT_W-1:0]   have_m1;
  logic               cur_free;
  logic [CNT_W:0]     avail;
  logic               tbl_we;
  logic [ADDR_W-1:0]  tbl_raddr;

  // Page size zero acts as one; frame count saturates at the frame total.
  assign ps_eff = (page_size == '0) ? PSZ_W'(1) : page_size;
  assign fc_eff = (frame_count > FC_W'(NUM_FRAMES)) ? FC_W'(NUM_FRAMES) : frame_count;

  // One restoring division step per cycle.
  assign rem_sh = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, ps_eff});

  assign have_m1  = have - CNT_W'(1);
  assign cur_free = frame_free[scan[FRAME_W-1:0]];
  assign avail    = {1'b0, nfree} + {1'b0, have};

  // Status toward the controller.
  always_comb begin
    stat.req         = req;
    stat.div_done    = (div_cnt == '0);
    stat.want_big    = (want > DVD_W'(MAX_PAGES));
    stat.grow        = (want > DVD_W'(have));
    stat.shrink      = (want < DVD_W'(have));
    stat.scan_end    = (scan >= fc_eff);
    stat.count_short = (avail < want[CNT_W:0]);
    stat.alloc_done  = (want[CNT_W-1:0] == have) || (scan >= fc_eff);
    stat.xlat_hit    = (page < PNUM_W'(have));
    stat.out_free    = !out_valid || out_ready;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size   <= PAGE_SIZE_RST;
      frame_count <= FRAME_COUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PAGE_SIZE) begin
        page_size <= cfg_data[PSZ_W-1:0];
      end else if (cfg_index == CFG_FRAME_COUNT) begin
        frame_count <= cfg_data[FC_W-1:0];
      end
    end
  end

  // Request capture, divider, working page count and scan counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= req_type;
      slot    <= proc_slot;
      page    <= page_number;
      dvd     <= {1'b0, new_size_bytes} + DVD_W'(ps_eff) - DVD_W'(1);
      rem     <= '0;
      want    <= '0;
      div_cnt <= (req_type == REQ_RESIZE) ? DIVC_W'(DVD_W) : '0;
      have    <= page_count[proc_slot];
    end
    if (cmd.div_step) begin
      dvd     <= {dvd[DVD_W-2:0], 1'b0};
      rem     <= rem_ge ? (rem_sh - {1'b0, ps_eff}) : rem_sh;
      want    <= {want[DVD_W-2:0], rem_ge};
      div_cnt <= div_cnt - DIVC_W'(1);
    end
    if (cmd.scan_clr) begin
      scan  <= '0;
      nfree <= '0;
    end
    if (cmd.count_step) begin
      nfree <= nfree + CNT_W'(cur_free);
      scan  <= scan + FC_W'(1);
    end
    if (cmd.alloc_step) begin
      if (cur_free) begin
        have <= have + CNT_W'(1);
      end
      scan <= scan + FC_W'(1);
    end
    if (cmd.shr_free) begin
      have <= have_m1;
    end
  end

  // Free-frame bitmap and per-slot page counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_free <= '1;
      for (int i = 0; i < NUM_PROCS; i++) begin
        page_count[i] <= '0;
      end
    end else begin
      if (cmd.alloc_step && cur_free) begin
        frame_free[scan[FRAME_W-1:0]] <= 1'b0;
      end
      if (cmd.shr_free) begin
        frame_free[rd_data] <= 1'b1;
      end
      if (cmd.commit) begin
        page_count[slot] <= have;
      end
    end
  end

  // Page table memory with registered read.
  assign tbl_we    = cmd.alloc_step && cur_free;
  assign tbl_raddr = cmd.xlat_rd ? {slot, page[PAGE_W-1:0]} : {slot, have_m1[PAGE_W-1:0]};

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[{slot, have[PAGE_W-1:0]}] <= scan[FRAME_W-1:0];
    end
    if (cmd.xlat_rd || cmd.shr_rd) begin
      rd_data <= table_mem[tbl_raddr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      status       <= cmd.out_status;
      frame_number <= cmd.out_frame_sel ? rd_data : '0;
    end
  end

endmodule

FILE: rtl/core/paged_frame_allocator.sv
// Paged frame allocator top level: joins the controller and the datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_dp.
//
// Usage: one request enters on in_valid/in_ready with req_type, proc_slot,
// page_number and new_size_bytes; exactly one result leaves on
// out_valid/out_ready with status and frame_number. Configuration writes
// (index 0 page size, index 1 frame count) are taken on cfg_valid and are
// always ready; write them only while the block is idle.
// Flow after acceptance: a translate passes dispatch, a page table read on a
// hit and the result; a release frees one page per table read until the slot
// is empty. A resize runs dispatch, the 17-step bit-serial divider and the
// size check. A shrink then frees pages as a release does. A grow scans the
// configured frames once to count free frames and, if enough are free, once
// more to allocate until the new size is reached, then gives the result. The
// frame scans are serial and the page table has a single read port.
// One request is worked at a time; the next is accepted once the result of
// the previous one sits in the output register, even if that result is not
// yet taken. If the receiver stalls, the next result waits inside and the
// input stalls.
// Reset marks every frame free, every slot empty, page size 32 and frame
// count 256; the page table needs no clearing pass.
module paged_frame_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pfa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CDAT_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pfa_pkg::REQ_W-1:0]    req_type,
  input  logic [3:0]                   proc_slot,
  input  logic [pfa_pkg::PNUM_W-1:0]   page_number,
  input  logic [pfa_pkg::BYTES_W-1:0]  new_size_bytes,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pfa_pkg::STAT_W-1:0]   status,
  output logic [7:0]                   frame_number
);
  import pfa_pkg::*;

  pfa_cmd_t  cmd;
  pfa_stat_t stat;

  assign cfg_ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .proc_slot      (proc_slot),
    .page_number    (page_number),
    .new_size_bytes (new_size_bytes),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .frame_number   (frame_number),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

FILE: rtl/core/pfa_checker.sv
// Port-level checks of the paged frame allocator, bound to the top level.
// Depends on pfa_pkg and paged_frame_allocator.
module pfa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pfa_pkg::STAT_W-1:0] status,
  input logic [7:0]                 frame_number
);
  import pfa_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_number))
    else $error("result changed while stalled");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_OOM || status == ST_NOT_FOUND))
    else $error("undefined status code");

  // A failed request carries frame zero.
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> frame_number == '0)
    else $error("nonzero frame on failure");

  // In the cycle after a request is accepted the block is not ready.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .frame_number (frame_number)
);
